### hw/rtl/spj2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spj2_pkg
// Shared widths and the item type passed from the front end to the root pipeline.
// ----------------------------------------------------------------------------
package spj2_pkg;

    localparam int PRS_W     = 32;
    localparam int ROOT_W    = 35;
    localparam int ROOT_BITS = 33;
    localparam int Y_W       = 67;

    typedef struct packed {
        logic [Y_W-1:0]   rad;
        logic [PRS_W-1:0] pressure;
    } item_t;

endpackage
`default_nettype wire

### hw/rtl/spj2_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spj2_front
// Five-stage front end: trace and differences, squares, sums, scaled radicand
// and the pressure quotient with its sign and saturation.
// ----------------------------------------------------------------------------
module spj2_front #(
    parameter int DIMENSIONS = 3
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_stress_xx,
    input  logic signed [31:0] s_stress_xy,
    input  logic signed [31:0] s_stress_xz,
    input  logic signed [31:0] s_stress_yy,
    input  logic signed [31:0] s_stress_yz,
    input  logic signed [31:0] s_stress_zz,
    output logic               item_valid,
    input  logic               item_ready,
    output spj2_pkg::item_t    item
);

    localparam int DIMS  = (DIMENSIONS < 1) ? 1 : ((DIMENSIONS > 3) ? 3 : DIMENSIONS);
    localparam int YW    = spj2_pkg::Y_W;
    localparam int PW    = spj2_pkg::PRS_W;
    localparam int SQW   = 64;
    localparam int SUMW  = 66;
    localparam int NUMW  = 33;
    localparam int HIW   = 16;
    localparam int LOW   = 17;
    localparam int XW    = 19;
    localparam int D3_QW = 18;
    localparam int D3_SH = 21;
    localparam logic [19:0] D3_MAGIC = 20'd699051;
    localparam logic [PW-1:0] PRS_MAX = 32'h7FFF_FFFF;

    function automatic logic [31:0] mag33(input logic signed [32:0] v);
        logic signed [32:0] n;
        n = -v;
        return v[32] ? n[31:0] : v[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        logic signed [31:0] n;
        n = -v;
        return v[31] ? n : v;
    endfunction

    function automatic logic [SQW-1:0] sq32(input logic [31:0] m);
        return SQW'(m) * SQW'(m);
    endfunction

    // floor(x / 3) for x below 2^19
    function automatic logic [D3_QW-1:0] div3(input logic [XW-1:0] x);
        logic [38:0] prod;
        prod = 39'(x) * 39'(D3_MAGIC);
        return prod[D3_SH +: D3_QW];
    endfunction

    logic [4:0] vld_reg;
    logic [4:0] vld_next;
    logic [4:0] rdy;

    logic signed [33:0] trc_reg, trc_next;
    logic signed [32:0] dab_reg, dab_next;
    logic signed [32:0] dbc_reg, dbc_next;
    logic signed [32:0] dca_reg, dca_next;
    logic signed [31:0] oxy_reg, oxy_next;
    logic signed [31:0] oxz_reg, oxz_next;
    logic signed [31:0] oyz_reg, oyz_next;

    logic [SQW-1:0]  sab_reg, sab_next;
    logic [SQW-1:0]  sbc_reg, sbc_next;
    logic [SQW-1:0]  sca_reg, sca_next;
    logic [SQW-1:0]  sxy_reg, sxy_next;
    logic [SQW-1:0]  sxz_reg, sxz_next;
    logic [SQW-1:0]  syz_reg, syz_next;
    logic [NUMW-1:0] num_reg, num_next;
    logic            neg2_reg, neg2_next;

    logic [SUMW-1:0] prad_reg, prad_next;
    logic [SUMW-1:0] shr_reg, shr_next;
    logic [HIW-1:0]  qhi_reg, qhi_next;
    logic [XW-1:0]   xlo_reg, xlo_next;
    logic            neg3_reg, neg3_next;

    logic [YW-1:0]   rad4_reg, rad4_next;
    logic [PW-1:0]   quo_reg, quo_next;
    logic            neg4_reg, neg4_next;

    logic [YW-1:0]   rad5_reg, rad5_next;
    logic [PW-1:0]   prs_reg, prs_next;

    logic signed [33:0] ntrc;
    logic [NUMW-1:0]    tmag;
    logic [HIW-1:0]     hi;
    logic [LOW-1:0]     lo;
    logic [HIW-1:0]     rh_full;
    logic [LOW-1:0]     qlo;
    logic [NUMW-1:0]    qcat;

    // handshake along the stages
    assign rdy[4]   = !vld_reg[4] || item_ready;
    assign rdy[3]   = !vld_reg[3] || rdy[4];
    assign rdy[2]   = !vld_reg[2] || rdy[3];
    assign rdy[1]   = !vld_reg[1] || rdy[2];
    assign rdy[0]   = !vld_reg[0] || rdy[1];
    assign s_ready  = rdy[0];

    always_comb begin
        vld_next[0] = rdy[0] ? s_valid : vld_reg[0];
        for (int k = 1; k < 5; k++) begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    // stage 1: trace, diagonal differences, used shear terms
    always_comb begin
        trc_next = 34'(s_stress_xx);
        dab_next = '0;
        dbc_next = '0;
        dca_next = '0;
        oxy_next = '0;
        oxz_next = '0;
        oyz_next = '0;
        if (DIMS == 2) begin
            trc_next = 34'(s_stress_xx) + 34'(s_stress_yy);
        end
        if (DIMS == 3) begin
            trc_next = 34'(s_stress_xx) + 34'(s_stress_yy) + 34'(s_stress_zz);
        end
        if (DIMS >= 2) begin
            dab_next = 33'(s_stress_xx) - 33'(s_stress_yy);
            oxy_next = s_stress_xy;
        end
        if (DIMS == 3) begin
            dbc_next = 33'(s_stress_yy) - 33'(s_stress_zz);
            dca_next = 33'(s_stress_zz) - 33'(s_stress_xx);
            oxz_next = s_stress_xz;
            oyz_next = s_stress_yz;
        end
    end

    // stage 2: squares, trace magnitude
    always_comb begin
        sab_next  = sq32(mag33(dab_reg));
        sbc_next  = sq32(mag33(dbc_reg));
        sca_next  = sq32(mag33(dca_reg));
        sxy_next  = sq32(mag32(oxy_reg));
        sxz_next  = sq32(mag32(oxz_reg));
        syz_next  = sq32(mag32(oyz_reg));
        ntrc      = -trc_reg;
        tmag      = trc_reg[33] ? ntrc[NUMW-1:0] : trc_reg[NUMW-1:0];
        num_next  = (DIMS == 2) ? (tmag >> 1) : tmag;
        neg2_next = trc_reg[33];
    end

    // stage 3: sums, upper quotient digit
    always_comb begin
        prad_next = SUMW'(sab_reg) + SUMW'(sbc_reg) + SUMW'(sca_reg);
        shr_next  = SUMW'(sxy_reg) + SUMW'(sxz_reg) + SUMW'(syz_reg);
        hi        = num_reg[NUMW-1:LOW];
        lo        = num_reg[LOW-1:0];
        rh_full   = '0;
        if (DIMS == 3) begin
            qhi_next = HIW'(div3(XW'(hi)));
            rh_full  = hi - (qhi_next << 1) - qhi_next;
            xlo_next = {rh_full[1:0], lo};
        end else begin
            qhi_next = hi;
            xlo_next = XW'(lo);
        end
        neg3_next = neg2_reg;
    end

    // stage 4: scaled radicand, lower quotient digit
    always_comb begin
        if (DIMS == 3) begin
            rad4_next = YW'({shr_reg, 1'b0}) + YW'(shr_reg) + YW'(prad_reg[SUMW-1:1]);
        end else if (DIMS == 2) begin
            rad4_next = YW'({shr_reg, 2'b00}) + YW'(prad_reg);
        end else begin
            rad4_next = '0;
        end
        qlo       = (DIMS == 3) ? LOW'(div3(xlo_reg)) : xlo_reg[LOW-1:0];
        qcat      = {qhi_reg, qlo};
        quo_next  = qcat[PW-1:0];
        neg4_next = neg3_reg;
    end

    // stage 5: sign the quotient (negated for a non-negative trace), saturate
    always_comb begin
        rad5_next = rad4_reg;
        if (neg4_reg) begin
            prs_next = quo_reg[PW-1] ? PRS_MAX : quo_reg;
        end else begin
            prs_next = PW'(0) - quo_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            trc_reg <= trc_next;
            dab_reg <= dab_next;
            dbc_reg <= dbc_next;
            dca_reg <= dca_next;
            oxy_reg <= oxy_next;
            oxz_reg <= oxz_next;
            oyz_reg <= oyz_next;
        end
        if (rdy[1]) begin
            sab_reg  <= sab_next;
            sbc_reg  <= sbc_next;
            sca_reg  <= sca_next;
            sxy_reg  <= sxy_next;
            sxz_reg  <= sxz_next;
            syz_reg  <= syz_next;
            num_reg  <= num_next;
            neg2_reg <= neg2_next;
        end
        if (rdy[2]) begin
            prad_reg <= prad_next;
            shr_reg  <= shr_next;
            qhi_reg  <= qhi_next;
            xlo_reg  <= xlo_next;
            neg3_reg <= neg3_next;
        end
        if (rdy[3]) begin
            rad4_reg <= rad4_next;
            quo_reg  <= quo_next;
            neg4_reg <= neg4_next;
        end
        if (rdy[4]) begin
            rad5_reg <= rad5_next;
            prs_reg  <= prs_next;
        end
    end

    assign item_valid    = vld_reg[4];
    assign item.rad      = rad5_reg;
    assign item.pressure = prs_reg;

endmodule
`default_nettype wire

### hw/rtl/spj2_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spj2_isqrt
// Restoring square-root pipeline, one root bit per stage, on a radicand that
// carries a fixed scale factor; pressure rides along.
// ----------------------------------------------------------------------------
module spj2_isqrt #(
    parameter int DIMENSIONS = 3
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  spj2_pkg::item_t               item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [spj2_pkg::PRS_W-1:0]    m_pressure,
    output logic [spj2_pkg::ROOT_W-1:0]   m_j2_root
);

    localparam int DIMS  = (DIMENSIONS < 1) ? 1 : ((DIMENSIONS > 3) ? 3 : DIMENSIONS);
    localparam int SCL   = (DIMS == 3) ? 3 : ((DIMS == 2) ? 4 : 1);
    localparam int STEPS = spj2_pkg::ROOT_BITS;
    localparam int YW    = spj2_pkg::Y_W;
    localparam int PW    = spj2_pkg::PRS_W;
    localparam int RW    = spj2_pkg::ROOT_W;
    localparam int SW    = STEPS + 2;
    localparam int TW    = 70;

    logic [STEPS-1:0] vld_reg;
    logic [STEPS-1:0] vld_next;
    logic [STEPS-1:0] vld_in;
    logic [STEPS-1:0] rdy;
    logic [STEPS-1:0] take;

    logic [YW-1:0]    rem_reg   [STEPS];
    logic [YW-1:0]    rem_next  [STEPS];
    logic [YW-1:0]    rem_in    [STEPS];
    logic [STEPS-1:0] root_reg  [STEPS];
    logic [STEPS-1:0] root_next [STEPS];
    logic [STEPS-1:0] root_in   [STEPS];
    logic [SW-1:0]    scl_reg   [STEPS];
    logic [SW-1:0]    scl_next  [STEPS];
    logic [SW-1:0]    scl_in    [STEPS];
    logic [PW-1:0]    prs_reg   [STEPS];
    logic [PW-1:0]    prs_next  [STEPS];
    logic [PW-1:0]    prs_in    [STEPS];
    logic [TW-1:0]    trial     [STEPS];
    logic [TW-1:0]    diff      [STEPS];

    // a stage moves when some stage from it to the output is free
    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            rdy[i] = m_ready || ((vld_reg | ~({STEPS{1'b1}} << i)) != {STEPS{1'b1}});
        end
    end

    assign item_ready = rdy[0];

    always_comb begin
        vld_in[0]  = item_valid;
        rem_in[0]  = item.rad;
        root_in[0] = '0;
        scl_in[0]  = '0;
        prs_in[0]  = item.pressure;
        for (int i = 1; i < STEPS; i++) begin
            vld_in[i]  = vld_reg[i-1];
            rem_in[i]  = rem_reg[i-1];
            root_in[i] = root_reg[i-1];
            scl_in[i]  = scl_reg[i-1];
            prs_in[i]  = prs_reg[i-1];
        end
    end

    // remainder holds rad - scl*root^2, scl_in holds scl*root
    always_comb begin
        for (int i = 0; i < STEPS; i++) begin
            trial[i]     = (TW'(scl_in[i]) << (STEPS - i)) |
                           (TW'(SCL) << (2 * (STEPS - 1 - i)));
            diff[i]      = TW'(rem_in[i]) - trial[i];
            take[i]      = TW'(rem_in[i]) >= trial[i];
            vld_next[i]  = rdy[i] ? vld_in[i] : vld_reg[i];
            rem_next[i]  = take[i] ? diff[i][YW-1:0] : rem_in[i];
            root_next[i] = take[i] ? (root_in[i] | (STEPS'(1) << (STEPS - 1 - i)))
                                   : root_in[i];
            scl_next[i]  = take[i] ? (scl_in[i] + (SW'(SCL) << (STEPS - 1 - i)))
                                   : scl_in[i];
            prs_next[i]  = prs_in[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < STEPS; i++) begin
            if (rdy[i]) begin
                rem_reg[i]  <= rem_next[i];
                root_reg[i] <= root_next[i];
                scl_reg[i]  <= scl_next[i];
                prs_reg[i]  <= prs_next[i];
            end
        end
    end

    assign m_valid    = vld_reg[STEPS-1];
    assign m_pressure = prs_reg[STEPS-1];
    assign m_j2_root  = RW'(root_reg[STEPS-1]);

endmodule
`default_nettype wire

### hw/rtl/stress_pressure_and_j2.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stress_pressure_and_j2
// Pressure and root of the second deviatoric stress invariant, streaming.
// ----------------------------------------------------------------------------
// Takes one symmetric stress tensor (signed Q16.16 components) per clock and
// returns minus the mean of the used diagonal terms and floor(sqrt(J2)) in
// Q16.16. Throughput is one tensor per cycle while the output is not stalled;
// each result passes in turn a five-stage front end and a 33-stage
// square-root pipeline that resolves one root bit per stage. DIMENSIONS
// (1 to 3) selects the axes used; components on unused axes are ignored, and
// with one axis the root is always zero. Each stage holds or moves on its
// own, so empty slots are squeezed out and input keeps flowing while a result
// waits at the output. The pressure saturates to the largest positive value
// when the mean is the most negative one.
module stress_pressure_and_j2 #(
    parameter int DIMENSIONS = 3
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [31:0]                s_stress_xx,
    input  logic signed [31:0]                s_stress_xy,
    input  logic signed [31:0]                s_stress_xz,
    input  logic signed [31:0]                s_stress_yy,
    input  logic signed [31:0]                s_stress_yz,
    input  logic signed [31:0]                s_stress_zz,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [spj2_pkg::PRS_W-1:0] m_pressure,
    output logic [spj2_pkg::ROOT_W-1:0]       m_j2_root
);

    logic            item_valid;
    logic            item_ready;
    spj2_pkg::item_t item;

    spj2_front #(
        .DIMENSIONS (DIMENSIONS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_stress_xx (s_stress_xx),
        .s_stress_xy (s_stress_xy),
        .s_stress_xz (s_stress_xz),
        .s_stress_yy (s_stress_yy),
        .s_stress_yz (s_stress_yz),
        .s_stress_zz (s_stress_zz),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    spj2_isqrt #(
        .DIMENSIONS (DIMENSIONS)
    ) u_isqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_pressure (m_pressure),
        .m_j2_root  (m_j2_root)
    );

endmodule
`default_nettype wire

### hw/rtl/spj2_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spj2_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module spj2_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [spj2_pkg::PRS_W-1:0] m_pressure,
    input logic [spj2_pkg::ROOT_W-1:0]       m_j2_root
);

    // nothing comes out of reset valid
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pressure) && $stable(m_j2_root))
        else $error("stalled result dropped or changed");

    // most negative pressure is saturated away
    a_prs_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pressure != {1'b1, {(spj2_pkg::PRS_W-1){1'b0}}})
        else $error("pressure not saturated");

    // root stays within the resolved bits
    a_root_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_j2_root >> spj2_pkg::ROOT_BITS) == '0)
        else $error("root above its bound");

endmodule

bind stress_pressure_and_j2 spj2_chk u_spj2_chk (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_pressure (m_pressure),
    .m_j2_root  (m_j2_root)
);
`default_nettype wire
